/* src/fsrq_pkg.sv */
// Shared types and constants for the fair share run queue.
package fsrq_pkg;

  localparam int unsigned NumSlots = 64;
  localparam int unsigned SlotW    = $clog2(NumSlots);
  localparam int unsigned VtW      = 48;
  localparam int unsigned TimeW    = 48;
  localparam int unsigned CntW     = $clog2(NumSlots + 1);
  localparam int unsigned GranW    = 32;
  localparam int unsigned StepW    = 16;
  localparam int unsigned CfgIdxW  = 1;

  localparam logic [CfgIdxW-1:0] CfgGranularity = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgVtimeStep   = 1'd1;

  localparam logic [GranW-1:0] GranReset = 32'd2000;
  localparam logic [StepW-1:0] StepReset = 16'd100;

  typedef enum logic [2:0] {
    OpAdd    = 3'd0,
    OpRemove = 3'd1,
    OpWake   = 3'd2,
    OpStop   = 3'd3,
    OpTick   = 3'd4,
    OpSched  = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    SlotReady   = 2'd0,
    SlotStopped = 2'd1,
    SlotRunning = 2'd2
  } slot_st_e;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StScan,
    StDrain,
    StFinish,
    StOut
  } fsm_e;

  // One entry of the slot memory.
  typedef struct packed {
    logic [VtW-1:0] vtime;
    logic [1:0]     st;
    logic           stop_pend;
  } slot_entry_t;

endpackage

/* src/fsrq_if.sv */
// Valid/ready channel interfaces for items and results.
interface fsrq_in_if;
  logic                                valid;
  logic                                ready;
  logic [2:0]                          operation;
  logic [fsrq_pkg::SlotW-1:0]          thread_id;
  logic [fsrq_pkg::TimeW-1:0]          now_us;
  modport source (output valid, operation, thread_id, now_us, input ready);
  modport sink   (input valid, operation, thread_id, now_us, output ready);
endinterface

interface fsrq_out_if;
  logic                                valid;
  logic                                ready;
  logic                                status;
  logic [fsrq_pkg::SlotW-1:0]          current_thread;
  logic                                switched;
  logic                                need_resched;
  logic [fsrq_pkg::CntW-1:0]           ready_count;
  modport source (output valid, status, current_thread, switched, need_resched, ready_count,
                  input ready);
  modport sink   (input valid, status, current_thread, switched, need_resched, ready_count,
                  output ready);
endinterface

/* src/fair_share_run_queue_unit.sv */
// Fair share run queue: slot memory, least virtual time scan and result register.
// Flow: add, remove, wake, stop and a schedule with the reschedule flag clear go from the read
// state to the result state; tick and a schedule with the flag set first scan the slots,
// reading one slot entry per cycle through the single read port, then drain and finish.
// Throughput: one transaction at a time; the next is taken once the result is registered.
// Reset (rst_ni low, asynchronous) clears slot use bits, counters and flags; slot memory
// contents stay undefined until an add writes them.
module fair_share_run_queue_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  fsrq_in_if.sink                          in_ch,
  fsrq_out_if.source                       out_ch,
  input  logic                             cfg_we_i,
  input  logic [fsrq_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [fsrq_pkg::GranW-1:0]       cfg_data_i
);

  localparam logic [fsrq_pkg::SlotW-1:0] LastSlot = fsrq_pkg::SlotW'(fsrq_pkg::NumSlots - 1);
  localparam logic [fsrq_pkg::VtW-1:0]   VtMax    = '1;

  fsrq_pkg::fsm_e state_q, state_d;

  logic [fsrq_pkg::GranW-1:0]    gran_q;
  logic [fsrq_pkg::StepW-1:0]    step_q;
  logic [fsrq_pkg::NumSlots-1:0] used_q, used_d;
  logic [fsrq_pkg::SlotW-1:0]    run_q, run_d;
  logic [fsrq_pkg::VtW-1:0]      idle_vt_q, idle_vt_d;
  logic                          resched_q, resched_d;
  logic [fsrq_pkg::TimeW-1:0]    last_sw_q, last_sw_d;
  logic [fsrq_pkg::CntW-1:0]     cnt_q, cnt_d;

  logic [2:0]                    op_q;
  logic [fsrq_pkg::SlotW-1:0]    tid_q;
  logic [fsrq_pkg::TimeW-1:0]    now_q;
  logic                          err_q, err_d;
  logic                          sw_q, sw_d;
  logic [fsrq_pkg::VtW-1:0]      cur_vt_q, cur_vt_d;

  logic [fsrq_pkg::SlotW-1:0]    scan_q, scan_d;
  logic                          pend_q, pend_d;
  logic [fsrq_pkg::SlotW-1:0]    pidx_q, pidx_d;
  logic                          found_q, found_d;
  logic [fsrq_pkg::SlotW-1:0]    best_q, best_d;
  logic [fsrq_pkg::VtW-1:0]      best_vt_q, best_vt_d;

  logic                          out_valid_q;
  logic                          load_out;

  fsrq_pkg::slot_entry_t         mem [fsrq_pkg::NumSlots];
  fsrq_pkg::slot_entry_t         rdata_q, wdata;
  logic [fsrq_pkg::SlotW-1:0]    raddr, waddr;
  logic                          we;

  logic                          in_acc;
  logic                          used_t;
  logic [fsrq_pkg::VtW:0]        vt_sum;
  logic [fsrq_pkg::VtW-1:0]      base_vt, sat_vt;
  logic [fsrq_pkg::TimeW-1:0]    delta;
  logic                          scan_ready;

  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_q == fsrq_pkg::StIdle);
  assign load_out    = (state_q == fsrq_pkg::StOut) && (!out_valid_q || out_ch.ready);
  assign used_t      = (tid_q != '0) && used_q[tid_q];

  // Saturating charge of the running thread.
  assign base_vt = (run_q == '0) ? idle_vt_q : rdata_q.vtime;
  assign vt_sum  = {1'b0, base_vt} + {{(fsrq_pkg::VtW + 1 - fsrq_pkg::StepW){1'b0}}, step_q};
  assign sat_vt  = vt_sum[fsrq_pkg::VtW] ? VtMax : vt_sum[fsrq_pkg::VtW-1:0];

  assign delta      = now_q - last_sw_q;
  assign scan_ready = (pidx_q != '0) && used_q[pidx_q] &&
                      (rdata_q.st == fsrq_pkg::SlotReady);

  // Slot memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      fsrq_pkg::StIdle: begin
        if (in_acc) state_d = fsrq_pkg::StRead;
      end
      fsrq_pkg::StRead: begin
        if (op_q == fsrq_pkg::OpTick ||
            (op_q == fsrq_pkg::OpSched && resched_q)) begin
          state_d = fsrq_pkg::StScan;
        end else begin
          state_d = fsrq_pkg::StOut;
        end
      end
      fsrq_pkg::StScan: begin
        if (scan_q == LastSlot) state_d = fsrq_pkg::StDrain;
      end
      fsrq_pkg::StDrain:  state_d = fsrq_pkg::StFinish;
      fsrq_pkg::StFinish: state_d = fsrq_pkg::StOut;
      fsrq_pkg::StOut: begin
        if (load_out) state_d = fsrq_pkg::StIdle;
      end
      default: state_d = fsrq_pkg::StIdle;
    endcase
  end

  // Datapath and memory control per state.
  always_comb begin
    used_d    = used_q;
    run_d     = run_q;
    idle_vt_d = idle_vt_q;
    resched_d = resched_q;
    last_sw_d = last_sw_q;
    cnt_d     = cnt_q;
    err_d     = err_q;
    sw_d      = sw_q;
    cur_vt_d  = cur_vt_q;
    scan_d    = scan_q;
    pend_d    = 1'b0;
    pidx_d    = pidx_q;
    found_d   = found_q;
    best_d    = best_q;
    best_vt_d = best_vt_q;
    we        = 1'b0;
    waddr     = tid_q;
    wdata     = rdata_q;
    raddr     = scan_q;

    case (state_q)
      fsrq_pkg::StIdle: begin
        err_d = 1'b0;
        sw_d  = 1'b0;
        if (in_ch.operation == fsrq_pkg::OpTick || in_ch.operation == fsrq_pkg::OpSched) begin
          raddr = run_q;
        end else begin
          raddr = in_ch.thread_id;
        end
      end

      fsrq_pkg::StRead: begin
        scan_d  = fsrq_pkg::SlotW'(1);
        found_d = 1'b0;
        case (op_q)
          fsrq_pkg::OpAdd: begin
            if (tid_q == '0 || used_q[tid_q]) begin
              err_d = 1'b1;
            end else begin
              used_d[tid_q]   = 1'b1;
              we              = 1'b1;
              wdata.vtime     = '0;
              wdata.st        = fsrq_pkg::SlotReady;
              wdata.stop_pend = 1'b0;
              cnt_d           = cnt_q + fsrq_pkg::CntW'(1);
            end
          end
          fsrq_pkg::OpRemove: begin
            if (!used_t || rdata_q.st == fsrq_pkg::SlotRunning) begin
              err_d = 1'b1;
            end else begin
              used_d[tid_q] = 1'b0;
              if (rdata_q.st == fsrq_pkg::SlotReady) cnt_d = cnt_q - fsrq_pkg::CntW'(1);
            end
          end
          fsrq_pkg::OpWake: begin
            if (tid_q != '0) begin
              if (!used_t || rdata_q.st == fsrq_pkg::SlotReady) begin
                err_d = 1'b1;
              end else if (rdata_q.st == fsrq_pkg::SlotStopped) begin
                we              = 1'b1;
                wdata.st        = fsrq_pkg::SlotReady;
                wdata.stop_pend = 1'b0;
                cnt_d           = cnt_q + fsrq_pkg::CntW'(1);
              end
            end
          end
          fsrq_pkg::OpStop: begin
            if (!used_t) begin
              err_d = 1'b1;
            end else if (rdata_q.st == fsrq_pkg::SlotRunning) begin
              we              = 1'b1;
              wdata.stop_pend = 1'b1;
              resched_d       = 1'b1;
            end else if (rdata_q.st == fsrq_pkg::SlotReady) begin
              we       = 1'b1;
              wdata.st = fsrq_pkg::SlotStopped;
              cnt_d    = cnt_q - fsrq_pkg::CntW'(1);
            end
          end
          fsrq_pkg::OpTick: begin
            cur_vt_d = sat_vt;
            if (run_q == '0) begin
              idle_vt_d = sat_vt;
            end else begin
              we          = 1'b1;
              waddr       = run_q;
              wdata.vtime = sat_vt;
            end
          end
          fsrq_pkg::OpSched: begin
            if (resched_q) begin
              resched_d = 1'b0;
              if (run_q != '0) begin
                we    = 1'b1;
                waddr = run_q;
                if (rdata_q.stop_pend) begin
                  wdata.st        = fsrq_pkg::SlotStopped;
                  wdata.stop_pend = 1'b0;
                end else begin
                  wdata.st = fsrq_pkg::SlotReady;
                  cnt_d    = cnt_q + fsrq_pkg::CntW'(1);
                end
              end
            end
          end
          default: err_d = 1'b1;
        endcase
      end

      fsrq_pkg::StScan, fsrq_pkg::StDrain: begin
        // Compare the entry returned for the previous address, then, while scanning, issue the next one.
        if (pend_q && scan_ready && (!found_q || rdata_q.vtime < best_vt_q)) begin
          found_d   = 1'b1;
          best_d    = pidx_q;
          best_vt_d = rdata_q.vtime;
        end
        if (state_q == fsrq_pkg::StScan) begin
          raddr  = scan_q;
          pend_d = 1'b1;
          pidx_d = scan_q;
          scan_d = scan_q + fsrq_pkg::SlotW'(1);
        end
      end

      fsrq_pkg::StFinish: begin
        if (op_q == fsrq_pkg::OpTick) begin
          if (found_q && (delta >= fsrq_pkg::TimeW'(gran_q)) &&
              (run_q == '0 || best_vt_q <= cur_vt_q)) begin
            resched_d = 1'b1;
          end
        end else begin
          run_d = found_q ? best_q : '0;
          if (found_q) begin
            we              = 1'b1;
            waddr           = best_q;
            wdata.vtime     = best_vt_q;
            wdata.st        = fsrq_pkg::SlotRunning;
            wdata.stop_pend = 1'b0;
            cnt_d           = cnt_q - fsrq_pkg::CntW'(1);
          end
          if (run_d != run_q) begin
            last_sw_d = now_q;
            sw_d      = 1'b1;
          end
        end
      end

      default: ;
    endcase
  end

  // Control state and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fsrq_pkg::StIdle;
      gran_q      <= fsrq_pkg::GranReset;
      step_q      <= fsrq_pkg::StepReset;
      used_q      <= '0;
      run_q       <= '0;
      idle_vt_q   <= '0;
      resched_q   <= 1'b0;
      last_sw_q   <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      used_q    <= used_d;
      run_q     <= run_d;
      idle_vt_q <= idle_vt_d;
      resched_q <= resched_d;
      last_sw_q <= last_sw_d;
      cnt_q     <= cnt_d;
      pend_q    <= pend_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          fsrq_pkg::CfgGranularity: gran_q <= cfg_data_i;
          fsrq_pkg::CfgVtimeStep:   step_q <= cfg_data_i[fsrq_pkg::StepW-1:0];
          default: ;
        endcase
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Transaction and scan payload registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= in_ch.operation;
      tid_q <= in_ch.thread_id;
      now_q <= in_ch.now_us;
    end
    err_q     <= err_d;
    sw_q      <= sw_d;
    cur_vt_q  <= cur_vt_d;
    scan_q    <= scan_d;
    pidx_q    <= pidx_d;
    found_q   <= found_d;
    best_q    <= best_d;
    best_vt_q <= best_vt_d;
    if (load_out) begin
      out_ch.status         <= err_q;
      out_ch.current_thread <= run_q;
      out_ch.switched       <= sw_q;
      out_ch.need_resched   <= resched_q;
      out_ch.ready_count    <= cnt_q;
    end
  end

  assign out_ch.valid = out_valid_q;

endmodule

/* src/fsrq_checker.sv */
// Port-level checker for the fair share run queue, bound to the run queue unit.
module fsrq_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic                        status_i,
  input logic                        switched_i,
  input logic                        need_resched_i,
  input logic [fsrq_pkg::CntW-1:0]   ready_count_i
);

  // A result transaction stays offered until it is taken.
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result valid dropped before acceptance");

  // The ready count never exceeds the number of slots.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ready_count_i <= fsrq_pkg::CntW'(fsrq_pkg::NumSlots))
    else $error("ready count out of range");

  // A switch comes only from a successful schedule.
  a_switch_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && switched_i |-> !status_i)
    else $error("switch reported with error status");

  // A schedule that switches has consumed the reschedule request.
  a_switch_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && switched_i |-> !need_resched_i)
    else $error("reschedule still pending after a switch");

endmodule

bind fair_share_run_queue_unit fsrq_checker u_fsrq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_ch.valid),
  .out_ready_i    (out_ch.ready),
  .status_i       (out_ch.status),
  .switched_i     (out_ch.switched),
  .need_resched_i (out_ch.need_resched),
  .ready_count_i  (out_ch.ready_count)
);

/* bench/tb.sv */
// Testbench for the fair share run queue: directed table, random traffic and a run queue predictor.
`timescale 1ns / 1ps

module tb;
  import fsrq_pkg::*;

  localparam logic [2:0] OpUnknown6 = 3'd6;
  localparam logic [2:0] OpUnknown7 = 3'd7;
  localparam logic [VtW-1:0] VtMax = {VtW{1'b1}};
  localparam int unsigned StallLimit = 5000;
  localparam int unsigned ItemsPerPhase = 250;
  localparam int unsigned NumPhases = 5;

  // Register settings used by the random phases.
  localparam logic [GranW-1:0] PhaseGran [NumPhases] =
    '{32'd2000, 32'd0, 32'hFFFF_FFFF, 32'd500, 32'd1500};
  localparam logic [StepW-1:0] PhaseStep [NumPhases] =
    '{16'd100, 16'd1, 16'hFFFF, 16'd0, 16'd250};

  typedef struct packed {
    logic             status;
    logic [SlotW-1:0] current_thread;
    logic             switched;
    logic             need_resched;
    logic [CntW-1:0]  ready_count;
  } sched_result_t;

  typedef struct packed {
    logic [2:0]       op;
    logic [SlotW-1:0] tid;
    logic [TimeW-1:0] now;
    logic             typed;
    sched_result_t    res;
  } table_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [GranW-1:0] cfg_data_i;

  fsrq_in_if  in_ch();
  fsrq_out_if out_ch();

  fair_share_run_queue_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Predictor state of the run queue.
  logic             rq_used [NumSlots];
  logic [VtW-1:0]   rq_vtime [NumSlots];
  slot_st_e         rq_state [NumSlots];
  logic             rq_stop_pend [NumSlots];
  logic [SlotW-1:0] rq_running;
  logic [VtW-1:0]   rq_idle_vtime;
  logic             rq_resched;
  logic [TimeW-1:0] rq_last_switch;
  logic [GranW-1:0] rq_granularity;
  logic [StepW-1:0] rq_step;

  sched_result_t pending_results[$];
  int unsigned   mismatch_count;
  int unsigned   results_seen;
  int unsigned   stall_cycles;
  logic [TimeW-1:0] clock_us;

  // Receiver stall control.
  logic        choppy_mode;
  int unsigned mode_left;
  int unsigned hold_left;
  logic        hold_done;

  // Sender burst control.
  int unsigned burst_left;

  initial clk_i = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [VtW-1:0] charge_vtime(logic [VtW-1:0] v);
    logic [VtW:0] sum;
    sum = {1'b0, v} + {{(VtW + 1 - StepW){1'b0}}, rq_step};
    return (sum > {1'b0, VtMax}) ? VtMax : sum[VtW-1:0];
  endfunction

  function automatic logic slot_is_ready(int unsigned s);
    return s != 0 && rq_used[s] && rq_state[s] == SlotReady;
  endfunction

  // Least ready virtual time, ties to the lowest slot; 0 when nothing is ready.
  function automatic logic [SlotW-1:0] least_ready_slot();
    logic [SlotW-1:0] best;
    best = '0;
    for (int unsigned s = 1; s < NumSlots; s++) begin
      if (slot_is_ready(s) && (best == 0 || rq_vtime[s] < rq_vtime[best])) best = SlotW'(s);
    end
    return best;
  endfunction

  function automatic logic [CntW-1:0] count_ready_slots();
    logic [CntW-1:0] n;
    n = '0;
    for (int unsigned s = 1; s < NumSlots; s++) if (slot_is_ready(s)) n++;
    return n;
  endfunction

  function automatic void reset_run_queue();
    for (int unsigned s = 0; s < NumSlots; s++) begin
      rq_used[s] = 1'b0;
      rq_vtime[s] = '0;
      rq_state[s] = SlotReady;
      rq_stop_pend[s] = 1'b0;
    end
    rq_running = '0;
    rq_idle_vtime = '0;
    rq_resched = 1'b0;
    rq_last_switch = '0;
    rq_granularity = GranReset;
    rq_step = StepReset;
  endfunction

  // Applies one transaction to the predicted run queue and returns its result.
  function automatic sched_result_t apply_run_queue_op(logic [2:0] op, logic [SlotW-1:0] tid,
                                                       logic [TimeW-1:0] now);
    sched_result_t r;
    logic used;
    logic [VtW-1:0] cur_vt;
    logic [SlotW-1:0] best;
    logic [SlotW-1:0] prev;
    r = '0;
    used = tid != 0 && rq_used[tid];
    case (op)
      OpAdd: begin
        if (tid == 0 || rq_used[tid]) r.status = 1'b1;
        else begin
          rq_used[tid] = 1'b1;
          rq_vtime[tid] = '0;
          rq_state[tid] = SlotReady;
          rq_stop_pend[tid] = 1'b0;
        end
      end
      OpRemove: begin
        if (!used || rq_state[tid] == SlotRunning) r.status = 1'b1;
        else rq_used[tid] = 1'b0;
      end
      OpWake: begin
        if (tid != 0) begin
          if (!used || rq_state[tid] == SlotReady) r.status = 1'b1;
          else if (rq_state[tid] == SlotStopped) begin
            rq_state[tid] = SlotReady;
            rq_stop_pend[tid] = 1'b0;
          end
        end
      end
      OpStop: begin
        if (!used) r.status = 1'b1;
        else if (rq_state[tid] == SlotRunning) begin
          rq_stop_pend[tid] = 1'b1;
          rq_resched = 1'b1;
        end else if (rq_state[tid] == SlotReady) rq_state[tid] = SlotStopped;
      end
      OpTick: begin
        if (rq_running == 0) begin
          rq_idle_vtime = charge_vtime(rq_idle_vtime);
          cur_vt = rq_idle_vtime;
        end else begin
          rq_vtime[rq_running] = charge_vtime(rq_vtime[rq_running]);
          cur_vt = rq_vtime[rq_running];
        end
        best = least_ready_slot();
        if ((now - rq_last_switch) >= TimeW'(rq_granularity) && best != 0) begin
          if (rq_running == 0 || rq_vtime[best] <= cur_vt) rq_resched = 1'b1;
        end
      end
      OpSched: begin
        if (rq_resched) begin
          prev = rq_running;
          rq_resched = 1'b0;
          if (prev != 0) begin
            if (rq_stop_pend[prev]) begin
              rq_state[prev] = SlotStopped;
              rq_stop_pend[prev] = 1'b0;
            end else rq_state[prev] = SlotReady;
          end
          best = least_ready_slot();
          if (best != 0) rq_state[best] = SlotRunning;
          if (best != prev) begin
            rq_last_switch = now;
            r.switched = 1'b1;
          end
          rq_running = best;
        end
      end
      default: r.status = 1'b1;
    endcase
    r.current_thread = rq_running;
    r.need_resched = rq_resched;
    r.ready_count = count_ready_slots();
    return r;
  endfunction

  // Directed rows; typed expectations only where they are obvious.
  table_row_t directed_rows [25] = '{
    '{OpTick,     6'd0,  48'd0, 1'b1, '{1'b0, 6'd0, 1'b0, 1'b0, 7'd0}},
    '{OpSched,    6'd0,  48'd0, 1'b1, '{1'b0, 6'd0, 1'b0, 1'b0, 7'd0}},
    '{OpAdd,      6'd0,  48'd0, 1'b1, '{1'b1, 6'd0, 1'b0, 1'b0, 7'd0}},
    '{OpRemove,   6'd0,  48'd0, 1'b1, '{1'b1, 6'd0, 1'b0, 1'b0, 7'd0}},
    '{OpStop,     6'd0,  48'd0, 1'b1, '{1'b1, 6'd0, 1'b0, 1'b0, 7'd0}},
    '{OpWake,     6'd0,  48'd0, 1'b1, '{1'b0, 6'd0, 1'b0, 1'b0, 7'd0}},
    '{OpUnknown6, 6'd5,  48'd0, 1'b1, '{1'b1, 6'd0, 1'b0, 1'b0, 7'd0}},
    '{OpUnknown7, 6'd63, 48'd0, 1'b1, '{1'b1, 6'd0, 1'b0, 1'b0, 7'd0}},
    '{OpRemove,   6'd63, 48'd0, 1'b1, '{1'b1, 6'd0, 1'b0, 1'b0, 7'd0}},
    '{OpWake,     6'd63, 48'd0, 1'b1, '{1'b1, 6'd0, 1'b0, 1'b0, 7'd0}},
    '{OpStop,     6'd63, 48'd0, 1'b1, '{1'b1, 6'd0, 1'b0, 1'b0, 7'd0}},
    '{OpAdd,      6'd63, 48'd0, 1'b1, '{1'b0, 6'd0, 1'b0, 1'b0, 7'd1}},
    '{OpAdd,      6'd63, 48'd0, 1'b1, '{1'b1, 6'd0, 1'b0, 1'b0, 7'd1}},
    '{OpWake,     6'd63, 48'd0, 1'b1, '{1'b1, 6'd0, 1'b0, 1'b0, 7'd1}},
    '{OpAdd,      6'd1,  48'd0, 1'b1, '{1'b0, 6'd0, 1'b0, 1'b0, 7'd2}},
    '{OpTick,     6'd0,  48'd5000, 1'b0, '0},
    '{OpSched,    6'd0,  48'd5000, 1'b0, '0},
    '{OpRemove,   6'd1,  48'd5000, 1'b0, '0},
    '{OpStop,     6'd1,  48'd5100, 1'b0, '0},
    '{OpSched,    6'd0,  48'd6000, 1'b0, '0},
    '{OpWake,     6'd1,  48'd6100, 1'b0, '0},
    '{OpStop,     6'd63, 48'd6200, 1'b0, '0},
    '{OpRemove,   6'd63, 48'd6300, 1'b0, '0},
    '{OpTick,     6'd0,  48'hFFFF_FFFF_FFFF, 1'b0, '0},
    '{OpSched,    6'd0,  48'hFFFF_FFFF_FFFF, 1'b0, '0}
  };

  // Offers one transaction, waits for acceptance and queues its expected result.
  task automatic send_item(logic [2:0] op, logic [SlotW-1:0] tid, logic [TimeW-1:0] now,
                           logic typed, sched_result_t typed_res);
    sched_result_t predicted;
    int unsigned gap;
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.thread_id <= tid;
    in_ch.now_us <= now;
    do @(posedge clk_i); while (!in_ch.ready);
    predicted = apply_run_queue_op(op, tid, now);
    pending_results = {pending_results, (typed ? typed_res : predicted)};
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic send_random_item();
    int unsigned pick;
    logic [2:0] op;
    logic [SlotW-1:0] tid;
    pick = $urandom_range(0, 99);
    if (pick < 20) op = OpAdd;
    else if (pick < 28) op = OpRemove;
    else if (pick < 40) op = OpWake;
    else if (pick < 52) op = OpStop;
    else if (pick < 77) op = OpTick;
    else if (pick < 97) op = OpSched;
    else op = ($urandom_range(0, 1) != 0) ? OpUnknown7 : OpUnknown6;
    tid = ($urandom_range(0, 4) == 0) ? SlotW'($urandom_range(0, NumSlots - 1))
                                      : SlotW'($urandom_range(0, 11));
    if ($urandom_range(0, 19) == 0) clock_us = TimeW'({$urandom(), $urandom()});
    else clock_us = clock_us + TimeW'($urandom_range(0, 3000));
    send_item(op, tid, clock_us, 1'b0, '0);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (NumSlots + 8) @(posedge clk_i);
  endtask

  // One register write, after which the write enable is dropped again.
  task automatic write_register(logic [CfgIdxW-1:0] idx, logic [GranW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == CfgGranularity) rq_granularity = data;
    else rq_step = data[StepW-1:0];
  endtask

  // Reset and stimulus.
  initial begin
    mismatch_count = 0;
    burst_left = 1;
    clock_us = '0;
    reset_run_queue();
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.operation = '0;
    in_ch.thread_id = '0;
    in_ch.now_us = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].op, directed_rows[i].tid, directed_rows[i].now,
                directed_rows[i].typed, directed_rows[i].res);
    end
    clock_us = 48'd10000;
    for (int unsigned p = 0; p < NumPhases; p++) begin
      wait_drained();
      write_register(CfgGranularity, PhaseGran[p]);
      write_register(CfgVtimeStep, GranW'(PhaseStep[p]));
      for (int unsigned n = 0; n < ItemsPerPhase; n++) begin
        // Once, halt offering until the queue has fully drained.
        if (p == 3 && n == ItemsPerPhase / 2) wait_drained();
        send_random_item();
      end
    end
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (NumSlots + 8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Receiver: calm and choppy stretches, plus one long hold-off.
  initial begin
    out_ch.ready = 1'b0;
    choppy_mode = 1'b0;
    mode_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    results_seen = 0;
  end

  always @(posedge clk_i) begin
    sched_result_t got;
    sched_result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.status, out_ch.current_thread, out_ch.switched, out_ch.need_resched,
              out_ch.ready_count};
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("Result transaction with no expected result waiting");
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (got != want) mismatch_count++;
        if (got.status != want.status)
          $error("status: expected %0d, actual %0d", want.status, got.status);
        if (got.current_thread != want.current_thread)
          $error("current_thread: expected %0d, actual %0d", want.current_thread,
                 got.current_thread);
        if (got.switched != want.switched)
          $error("switched: expected %0d, actual %0d", want.switched, got.switched);
        if (got.need_resched != want.need_resched)
          $error("need_resched: expected %0d, actual %0d", want.need_resched,
                 got.need_resched);
        if (got.ready_count != want.ready_count)
          $error("ready_count: expected %0d, actual %0d", want.ready_count, got.ready_count);
      end
    end
    if (!hold_done && results_seen == 400) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (mode_left == 0) begin
      choppy_mode <= ($urandom_range(0, 1) != 0);
      mode_left <= $urandom_range(10, 80);
      out_ch.ready <= 1'b1;
    end else begin
      mode_left <= mode_left - 1;
      out_ch.ready <= choppy_mode ? ($urandom_range(0, 1) != 0) : 1'b1;
    end
  end

  // Watchdog on cycles with no transaction on either channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule
